FILE: src/swsr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the single-wire sensor reader.
// Used by swsr_cfg, swsr_fsm and the top level single_wire_sensor_reader_unit.
package swsr_pkg;

    localparam int FRAME_BITS  = 40;
    localparam int BIT_CNT_W   = 6;
    localparam int START_LOW_W = 16;
    localparam int CFG_W       = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_START_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESP_TMO     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_LOW_TMO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_HIGH_TMO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_THRESH   = 3'd5;

    localparam logic [START_LOW_W-1:0] RST_START_LOW    = 16'd10000;
    localparam logic [CFG_W-1:0]       RST_RELEASE_HIGH = 8'd15;
    localparam logic [CFG_W-1:0]       RST_RESP_TMO     = 8'd50;
    localparam logic [CFG_W-1:0]       RST_BIT_LOW_TMO  = 8'd35;
    localparam logic [CFG_W-1:0]       RST_BIT_HIGH_TMO = 8'd45;
    localparam logic [CFG_W-1:0]       RST_ONE_THRESH   = 8'd20;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TIMEOUT  = 2'd1;
    localparam logic [1:0] ST_CHECKSUM = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_START_LOW  = 4'd1,
        PH_START_HIGH = 4'd2,
        PH_RESP_LOW   = 4'd3,
        PH_RESP_HIGH  = 4'd4,
        PH_RESP_DATA  = 4'd5,
        PH_BIT_RISE   = 4'd6,
        PH_BIT_HIGH   = 4'd7
    } t_phase;

    typedef struct packed {
        logic [START_LOW_W-1:0] start_low;
        logic [CFG_W-1:0]       release_high;
        logic [CFG_W-1:0]       resp_tmo;
        logic [CFG_W-1:0]       bit_low_tmo;
        logic [CFG_W-1:0]       bit_high_tmo;
        logic [CFG_W-1:0]       one_thresh;
    } t_cfg;

    typedef struct packed {
        logic       drive_enable;
        logic       drive_value;
        logic       busy;
        logic       done;
        logic [1:0] status;
        logic [7:0] humidity_int;
        logic [7:0] humidity_frac;
        logic [7:0] temperature_int;
        logic [7:0] temperature_frac;
    } t_result;

endpackage

FILE: src/swsr_cfg.sv
`timescale 1ns / 1ps
// Configuration register bank: timing bounds and decode threshold.
// Depends on swsr_pkg for register indexes, reset values and t_cfg.
module swsr_cfg import swsr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_low    <= RST_START_LOW;
            r_cfg.release_high <= RST_RELEASE_HIGH;
            r_cfg.resp_tmo     <= RST_RESP_TMO;
            r_cfg.bit_low_tmo  <= RST_BIT_LOW_TMO;
            r_cfg.bit_high_tmo <= RST_BIT_HIGH_TMO;
            r_cfg.one_thresh   <= RST_ONE_THRESH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_LOW:    r_cfg.start_low    <= i_cfg_wdata;
                CFG_RELEASE_HIGH: r_cfg.release_high <= i_cfg_wdata[CFG_W-1:0];
                CFG_RESP_TMO:     r_cfg.resp_tmo     <= i_cfg_wdata[CFG_W-1:0];
                CFG_BIT_LOW_TMO:  r_cfg.bit_low_tmo  <= i_cfg_wdata[CFG_W-1:0];
                CFG_BIT_HIGH_TMO: r_cfg.bit_high_tmo <= i_cfg_wdata[CFG_W-1:0];
                CFG_ONE_THRESH:   r_cfg.one_thresh   <= i_cfg_wdata[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/swsr_fsm.sv
`timescale 1ns / 1ps
// Read protocol sequencer: start pulse, response waits, bit timing and frame check.
// Depends on swsr_pkg for t_phase, t_cfg, t_result and status codes.
module swsr_fsm import swsr_pkg::*; #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic    i_req,
    input  logic    i_line,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    localparam int LW = (COUNT_WIDTH > START_LOW_W) ? COUNT_WIDTH : START_LOW_W;
    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
    localparam logic [COUNT_WIDTH-1:0] ONE  = COUNT_WIDTH'(1);

    t_phase                 r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_tick,  n_tick;
    logic [BIT_CNT_W-1:0]   r_bits,  n_bits;
    logic [FRAME_BITS-1:0]  r_frame, n_frame;

    logic [LW-1:0]          w_tick_x;
    logic [LW-1:0]          w_cmax_x;
    logic [LW-1:0]          w_start_len;
    logic [LW-1:0]          w_release_len;
    logic [COUNT_WIDTH-1:0] w_tick_sat;
    logic                   w_is_wait;
    logic                   w_want;
    logic [CFG_W-1:0]       w_bound;
    logic                   w_hit;
    logic                   w_tmo;
    logic                   w_bit_val;
    logic [FRAME_BITS-1:0]  w_frame_new;
    logic [BIT_CNT_W-1:0]   w_bits_new;
    logic                   w_last;
    logic [7:0]             w_sum;

    assign w_tick_x      = LW'(r_tick);
    assign w_cmax_x      = LW'(CMAX);
    assign w_start_len   = (LW'(i_cfg.start_low) > w_cmax_x) ? w_cmax_x
                                                             : LW'(i_cfg.start_low);
    assign w_release_len = (LW'(i_cfg.release_high) > w_cmax_x) ? w_cmax_x
                                                                : LW'(i_cfg.release_high);
    assign w_tick_sat    = (r_tick == CMAX) ? r_tick : r_tick + ONE;

    always_comb begin
        w_is_wait = 1'b1;
        w_want    = 1'b0;
        w_bound   = i_cfg.resp_tmo;
        unique case (r_phase)
            PH_RESP_LOW:  w_want = 1'b0;
            PH_RESP_HIGH: w_want = 1'b1;
            PH_RESP_DATA: w_want = 1'b0;
            PH_BIT_RISE: begin
                w_want  = 1'b1;
                w_bound = i_cfg.bit_low_tmo;
            end
            PH_BIT_HIGH: begin
                w_want  = 1'b0;
                w_bound = i_cfg.bit_high_tmo;
            end
            default: w_is_wait = 1'b0;
        endcase
    end

    assign w_hit       = (i_line == w_want);
    assign w_tmo       = !w_hit && (w_tick_x >= LW'(w_bound));
    assign w_bit_val   = (w_tick_x > LW'(i_cfg.one_thresh));
    assign w_frame_new = {r_frame[FRAME_BITS-2:0], w_bit_val};
    assign w_bits_new  = r_bits + BIT_CNT_W'(1);
    assign w_last      = (w_bits_new >= BIT_CNT_W'(FRAME_BITS));
    assign w_sum       = w_frame_new[39:32] + w_frame_new[31:24]
                       + w_frame_new[23:16] + w_frame_new[15:8];

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_bits  = r_bits;
        n_frame = r_frame;
        unique case (r_phase)
            PH_START_LOW: begin
                if (w_tick_x >= w_start_len) begin
                    n_phase = PH_START_HIGH;
                    n_tick  = ONE;
                end else begin
                    n_tick = w_tick_sat;
                end
            end
            PH_START_HIGH: begin
                if (w_tick_x >= w_release_len) begin
                    n_phase = PH_RESP_LOW;
                    n_tick  = '0;
                end else begin
                    n_tick = w_tick_sat;
                end
            end
            PH_RESP_LOW, PH_RESP_HIGH, PH_RESP_DATA, PH_BIT_RISE: begin
                if (w_hit) begin
                    n_tick = '0;
                    unique case (r_phase)
                        PH_RESP_LOW:  n_phase = PH_RESP_HIGH;
                        PH_RESP_HIGH: n_phase = PH_RESP_DATA;
                        PH_RESP_DATA: n_phase = PH_BIT_RISE;
                        default:      n_phase = PH_BIT_HIGH;
                    endcase
                end else if (w_tmo) begin
                    n_phase = PH_IDLE;
                    n_tick  = '0;
                end else begin
                    n_tick = w_tick_sat;
                end
            end
            PH_BIT_HIGH: begin
                if (w_hit) begin
                    n_frame = w_frame_new;
                    n_bits  = w_bits_new;
                    n_tick  = '0;
                    n_phase = w_last ? PH_IDLE : PH_BIT_RISE;
                end else if (w_tmo) begin
                    n_phase = PH_IDLE;
                    n_tick  = '0;
                end else begin
                    n_tick = w_tick_sat;
                end
            end
            default: begin
                if (i_req) begin
                    n_phase = PH_START_LOW;
                    n_tick  = ONE;
                    n_bits  = '0;
                    n_frame = '0;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
        endcase
    end

    // Outputs
    always_comb begin
        logic w_emit;
        w_emit             = (r_phase == PH_BIT_HIGH) && w_hit && w_last;
        o_res              = '0;
        o_res.drive_enable = (n_phase == PH_START_LOW) || (n_phase == PH_START_HIGH);
        o_res.drive_value  = (n_phase == PH_START_HIGH);
        o_res.busy         = (n_phase != PH_IDLE);
        if (w_is_wait && w_tmo) begin
            o_res.done   = 1'b1;
            o_res.status = ST_TIMEOUT;
        end else if (w_emit) begin
            o_res.done             = 1'b1;
            o_res.status           = (w_sum == w_frame_new[7:0]) ? ST_OK : ST_CHECKSUM;
            o_res.humidity_int     = w_frame_new[39:32];
            o_res.humidity_frac    = w_frame_new[31:24];
            o_res.temperature_int  = w_frame_new[23:16];
            o_res.temperature_frac = w_frame_new[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_bits  <= '0;
            r_frame <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bits  <= n_bits;
            r_frame <= n_frame;
        end
    end

endmodule

FILE: src/single_wire_sensor_reader_unit.sv
`timescale 1ns / 1ps
// Top level of the single-wire sensor reader: input register, sequencer, result register.
// Depends on swsr_pkg, swsr_cfg and swsr_fsm.
//
//  channel | dir | width | contents
//  s_axis  | in  | 8     | tick word: start_request, line_level
//  m_axis  | out | 40    | result word: drive, busy, done, status, four data bytes
//  cfg     | in  | 3+16  | register index, write data
//
// One tick word enters per cycle while the result side does not stall; its result leaves
// through the input register, then a sequencer step into the result register.
// Every accepted tick word yields exactly one result word.
// Reset is synchronous and active low; it clears the sequencer and restores register defaults.
// A stall on the result side backs up through the input register into o_s_tready.
module single_wire_sensor_reader_unit import swsr_pkg::*; #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [0] start_request, [1] line_level
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // [0] drive_enable, [1] drive_value,
                                                // [2] busy_res, [3] done_res, [5:4] status,
                                                // [13:6] humidity_int, [21:14] humidity_frac,
                                                // [29:22] temperature_int,
                                                // [37:30] temperature_frac
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    logic    r_in_valid;
    logic    r_in_req;
    logic    r_in_line;
    logic    r_out_valid;
    t_result r_out;
    logic    w_adv;
    t_cfg    w_cfg;
    t_result w_res;

    assign w_adv      = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_adv;

    swsr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    swsr_fsm #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_adv),
        .i_req   (r_in_req),
        .i_line  (r_in_line),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_req  <= i_s_tdata[0];
            r_in_line <= i_s_tdata[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out.temperature_frac, r_out.temperature_int,
                         r_out.humidity_frac, r_out.humidity_int, r_out.status,
                         r_out.done, r_out.busy, r_out.drive_value, r_out.drive_enable};

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done) |-> !r_out.busy)
        else $error("finished read still reported busy");

    a_status_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.done) |-> (r_out.status == ST_OK))
        else $error("nonzero status without done");

    a_stall_backs_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_m_tready) |-> !o_s_tready)
        else $error("input accepted while both stages are full and stalled");

    a_result_follows_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("sequencer step produced no result word");

endmodule
